// ===== src/aplc_pkg.sv =====
package aplc_pkg;

   localparam int unsigned POS_W = 11;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
   localparam logic [POS_W-1:0] HDR_END = POS_W'(5);
   localparam logic [POS_W-1:0] LEN_BASE = POS_W'(10);
   localparam logic [POS_W-1:0] TRAILER_LEN = POS_W'(5);

   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_ETX = 8'h03;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   localparam logic [3:0] NIB_DEC_MAX = 4'h9;
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_ALPHA_BASE = 8'h37;

   typedef enum logic {
      KIND_DATA = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_SHORT = 2'd1,
      STATUS_BAD = 2'd2
   } status_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] nib_ext;
      nib_ext = {4'h0, nib};
      if (nib <= NIB_DEC_MAX) begin
         return nib_ext + ASCII_ZERO;
      end
      return nib_ext + ASCII_ALPHA_BASE;
   endfunction

endpackage

// ===== src/ascii_plc_read_response_checker_top.sv =====
// read-response frame checker for an ascii serial plc link
// req channel: one received frame byte per beat (req_rx_byte), the requested
//   word count (req_word_count, held for the whole frame) and req_frame_end on
//   the last byte of the frame
// rsp channel: rsp_kind data gives a payload byte in rsp_data_byte as soon as
//   it arrives; rsp_kind status gives rsp_frame_status on the frame_end beat
//   (ok, too short, bad framing or checksum)
// expected frame length is 4*word_count+10; bytes beyond it are dropped
// a taken beat's result is registered in the output register (skid if held)
// throughput: one beat per cycle when not stalled; per-beat check is a compare
//   and an add between the position/sum registers and the result register
// a two-entry result stage (output register plus skid register) lets beats
//   keep flowing while a result waits; req_stall rises only when both hold a
//   result, i.e. only after the receiver has stalled with a result waiting
// a data byte on the frame_end beat is not passed out, only the status
// reset (synchronous, active high) empties the result stage and clears the
//   position, checksum and mismatch state; the frame_end beat does the same
//   to the frame state so the next beat starts a new frame
module ascii_plc_read_response_checker_top
   import aplc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   input  logic [7:0] req_word_count,
   input  logic       req_frame_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [1:0] rsp_frame_status
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic mis_ff, mis_in;

   logic out_valid_ff, out_valid_in;
   kind_type out_kind_ff, out_kind_in;
   logic [7:0] out_data_ff, out_data_in;
   status_type out_status_ff, out_status_in;

   logic skid_valid_ff, skid_valid_in;
   kind_type skid_kind_ff, skid_kind_in;
   logic [7:0] skid_data_ff, skid_data_in;
   status_type skid_status_ff, skid_status_in;

   logic accept;
   logic take;
   logic [POS_W-1:0] frame_len;
   logic [POS_W-1:0] etx_pos;
   logic [POS_W:0] pos_next_wide;
   logic in_frame;
   logic bad_byte;
   logic is_data;
   logic [7:0] sum_add;
   logic res_valid;
   kind_type res_kind;
   logic [7:0] res_data;
   status_type res_status;

   assign accept = req_valid && !req_stall;
   assign take = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;

   assign frame_len = {1'b0, req_word_count, 2'b00} + LEN_BASE;
   assign etx_pos = frame_len - TRAILER_LEN;
   assign pos_next_wide = {1'b0, pos_ff} + (POS_W+1)'(1);
   assign in_frame = pos_ff < frame_len;
   assign sum_add = sum_ff + req_rx_byte;

   // position decode of the current beat
   always_comb begin
      bad_byte = 1'b0;
      is_data = 1'b0;
      sum_in = sum_ff;
      if (in_frame) begin
         priority if (pos_ff == '0) begin
            bad_byte = req_rx_byte != CH_STX;
         end else if (pos_ff < etx_pos) begin
            sum_in = sum_add;
            is_data = pos_ff >= HDR_END;
         end else if (pos_ff == etx_pos) begin
            sum_in = sum_add;
            bad_byte = req_rx_byte != CH_ETX;
         end else if (pos_ff == etx_pos + POS_W'(1)) begin
            bad_byte = req_rx_byte != hex_digit(sum_ff[7:4]);
         end else if (pos_ff == etx_pos + POS_W'(2)) begin
            bad_byte = req_rx_byte != hex_digit(sum_ff[3:0]);
         end else if (pos_ff == etx_pos + POS_W'(3)) begin
            bad_byte = req_rx_byte != CH_CR;
         end else begin
            bad_byte = req_rx_byte != CH_LF;
         end
      end
      mis_in = mis_ff || bad_byte;
      pos_in = (pos_ff == POS_MAX) ? pos_ff : pos_next_wide[POS_W-1:0];

      res_valid = is_data;
      res_kind = KIND_DATA;
      res_data = req_rx_byte;
      res_status = STATUS_OK;
      if (req_frame_end) begin
         res_valid = 1'b1;
         res_kind = KIND_STATUS;
         res_data = '0;
         priority if (pos_next_wide < {1'b0, frame_len}) begin
            res_status = STATUS_SHORT;
         end else if (mis_in) begin
            res_status = STATUS_BAD;
         end else begin
            res_status = STATUS_OK;
         end
         pos_in = '0;
         sum_in = '0;
         mis_in = 1'b0;
      end
   end

   // two-entry result stage
   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in = out_kind_ff;
      out_data_in = out_data_ff;
      out_status_in = out_status_ff;
      skid_valid_in = skid_valid_ff;
      skid_kind_in = skid_kind_ff;
      skid_data_in = skid_data_ff;
      skid_status_in = skid_status_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in = 1'b1;
            out_kind_in = skid_kind_ff;
            out_data_in = skid_data_ff;
            out_status_in = skid_status_ff;
            skid_valid_in = 1'b0;
         end else if (accept && res_valid) begin
            out_valid_in = 1'b1;
            out_kind_in = res_kind;
            out_data_in = res_data;
            out_status_in = res_status;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept && res_valid) begin
         skid_valid_in = 1'b1;
         skid_kind_in = res_kind;
         skid_data_in = res_data;
         skid_status_in = res_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
         mis_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff <= pos_in;
            sum_ff <= sum_in;
            mis_ff <= mis_in;
         end
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_data_ff <= out_data_in;
      out_status_ff <= out_status_in;
      skid_kind_ff <= skid_kind_in;
      skid_data_ff <= skid_data_in;
      skid_status_ff <= skid_status_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind = out_kind_ff;
   assign rsp_data_byte = out_data_ff;
   assign rsp_frame_status = out_status_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a beat while output register is empty");

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_frame_end |=> pos_ff == '0 && sum_ff == '0 && !mis_ff)
      else $error("frame state not cleared after frame end");

   a_status_no_data: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff == KIND_STATUS |-> out_data_ff == '0)
      else $error("status beat carries a data byte");

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      accept && !req_frame_end && pos_ff != POS_MAX |=>
         pos_ff == $past(pos_ff) + POS_W'(1))
      else $error("byte position did not advance");

endmodule
